>>> rtl/tsd_pkg.sv
// shared types and constants of the depth-first topological sort block
package tsd_pkg;

  localparam int NODE_W        = 6;
  localparam int COUNT_W       = 7;
  localparam int MAX_NODES_DEF = 64;
  localparam logic [COUNT_W-1:0] NODE_COUNT_RST = 7'd64;

  typedef enum logic [1:0] {
    CMD_ADD_EDGE = 2'd0,
    CMD_RUN      = 2'd1,
    CMD_CLEAR    = 2'd2
  } cmd_e;

  typedef struct packed {
    logic [NODE_W-1:0]  node;
    logic [COUNT_W-1:0] next;
  } walk_entry_t;

  typedef struct packed {
    logic              rd_en;
    logic [NODE_W-1:0] rd_addr;
    logic              wr_en;
    logic [NODE_W-1:0] wr_addr;
    logic              clear;
  } adj_ctrl_t;

  typedef struct packed {
    logic              rd_en;
    logic [NODE_W-1:0] rd_addr;
    logic              wr_en;
    logic [NODE_W-1:0] wr_addr;
    walk_entry_t       wr_data;
  } walk_ctrl_t;

  typedef struct packed {
    logic              load;
    logic [NODE_W-1:0] node;
    logic              last;
    logic              no_order;
  } out_load_t;

endpackage

>>> rtl/tsd_req_if.sv
// request and result channel interfaces
interface tsd_req_if import tsd_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [1:0]        command;
  logic [NODE_W-1:0] from_node;
  logic [NODE_W-1:0] to_node;

  modport source (output valid, command, from_node, to_node, input ready);
  modport sink   (input valid, command, from_node, to_node, output ready);
endinterface

interface tsd_rsp_if import tsd_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [NODE_W-1:0] node;
  logic              last;
  logic              no_order;

  modport source (output valid, node, last, no_order, input ready);
  modport sink   (input valid, node, last, no_order, output ready);
endinterface

>>> rtl/topological_sort_dfs.sv
// top level: depth-first topological sort over an adjacency bit matrix
//
//   channel   dir  signals                               moves
//   req_i     in   valid ready command from_node to_node one request per handshake
//   rsp_o     out  valid ready node last no_order        one result per handshake
//   cfg       in   cfg_we_i cfg_wdata_i                  node count register write
//
// add edge reads the row, then writes it back with the new bit set; clear is done from idle.
// a run with n nodes tests one adjacency bit per cycle in the walk loop, with extra steps
// for each return to a parent and each start node; then each emitted node is read from the
// order memory before it is loaded. reset clears row valid bits at once, no sweep.
// results sit in an output register; a stalled result holds the readout, and a new
// request is taken as soon as the previous run has handed its last result to that register.
module topological_sort_dfs import tsd_pkg::*; #(
  parameter int MAX_NODES = MAX_NODES_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  tsd_req_if.sink            req_i,
  tsd_rsp_if.source          rsp_o,
  input  logic               cfg_we_i,
  input  logic [COUNT_W-1:0] cfg_wdata_i
);

  logic [COUNT_W-1:0]   node_count_q;
  logic                 out_valid_q;
  logic [NODE_W-1:0]    out_node_q;
  logic                 out_last_q;
  logic                 out_no_order_q;
  logic                 slot_free;
  adj_ctrl_t            adj_ctrl;
  logic [MAX_NODES-1:0] adj_wdata;
  logic [MAX_NODES-1:0] adj_row;
  walk_ctrl_t           walk_ctrl;
  walk_entry_t          walk_rdata;
  out_load_t            out_load;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      node_count_q <= NODE_COUNT_RST;
    end else if (cfg_we_i) begin
      node_count_q <= cfg_wdata_i;
    end
  end

  assign slot_free = !out_valid_q || rsp_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load.load) begin
      out_valid_q <= 1'b1;
    end else if (rsp_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load.load) begin
      out_node_q     <= out_load.node;
      out_last_q     <= out_load.last;
      out_no_order_q <= out_load.no_order;
    end
  end

  assign rsp_o.valid    = out_valid_q;
  assign rsp_o.node     = out_node_q;
  assign rsp_o.last     = out_last_q;
  assign rsp_o.no_order = out_no_order_q;

  tsd_dfs_ctrl #(
    .MAX_NODES(MAX_NODES)
  ) u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .node_count_i (node_count_q),
    .in_valid_i   (req_i.valid),
    .in_ready_o   (req_i.ready),
    .command_i    (req_i.command),
    .from_node_i  (req_i.from_node),
    .to_node_i    (req_i.to_node),
    .adj_ctrl_o   (adj_ctrl),
    .adj_wdata_o  (adj_wdata),
    .adj_row_i    (adj_row),
    .walk_ctrl_o  (walk_ctrl),
    .walk_rdata_i (walk_rdata),
    .slot_free_i  (slot_free),
    .out_load_o   (out_load)
  );

  tsd_adj_store #(
    .MAX_NODES(MAX_NODES)
  ) u_adj (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctrl_i  (adj_ctrl),
    .wdata_i (adj_wdata),
    .row_o   (adj_row)
  );

  tsd_walk_store #(
    .MAX_NODES(MAX_NODES)
  ) u_walk (
    .clk_i   (clk_i),
    .ctrl_i  (walk_ctrl),
    .rdata_o (walk_rdata)
  );

`ifndef SYNTHESIS
  // a held result is never overwritten
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load.load |-> (!out_valid_q || rsp_o.ready))
    else $error("result register overwritten while stalled");

  // order writes and stack reads never hit the same entry
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (walk_ctrl.wr_en && walk_ctrl.rd_en) |-> (walk_ctrl.wr_addr != walk_ctrl.rd_addr))
    else $error("walk memory read and write collide");

  // a cycle report is always the single final result of its run
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_load.load && out_load.no_order) |-> out_load.last)
    else $error("cycle report without last");

  // no request is taken while a loaded result of the same cycle is being produced
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load.load |-> !(req_i.valid && req_i.ready))
    else $error("request accepted during readout");
`endif

endmodule

>>> rtl/tsd_adj_store.sv
// adjacency matrix memory with per-row valid bits
module tsd_adj_store import tsd_pkg::*; #(
  parameter int MAX_NODES = MAX_NODES_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  adj_ctrl_t            ctrl_i,
  input  logic [MAX_NODES-1:0] wdata_i,
  output logic [MAX_NODES-1:0] row_o
);

  localparam int NW = $clog2(MAX_NODES);

  logic [MAX_NODES-1:0] mem_q [MAX_NODES];
  logic [MAX_NODES-1:0] rdata_q;
  logic [MAX_NODES-1:0] row_valid_q;
  logic                 rvalid_q;

  always_ff @(posedge clk_i) begin
    if (ctrl_i.wr_en) begin
      mem_q[ctrl_i.wr_addr[NW-1:0]] <= wdata_i;
    end
    if (ctrl_i.rd_en) begin
      rdata_q <= mem_q[ctrl_i.rd_addr[NW-1:0]];
    end
  end

  // a row never written since the last clear reads as no edges
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_valid_q <= '0;
      rvalid_q    <= 1'b0;
    end else begin
      if (ctrl_i.clear) begin
        row_valid_q <= '0;
      end else if (ctrl_i.wr_en) begin
        row_valid_q[ctrl_i.wr_addr[NW-1:0]] <= 1'b1;
      end
      if (ctrl_i.rd_en) begin
        rvalid_q <= row_valid_q[ctrl_i.rd_addr[NW-1:0]];
      end
    end
  end

  assign row_o = rvalid_q ? rdata_q : '0;

endmodule

>>> rtl/tsd_walk_store.sv
// walk stack and order memory, stack grows up from 0, order fills down from the count
module tsd_walk_store import tsd_pkg::*; #(
  parameter int MAX_NODES = MAX_NODES_DEF
) (
  input  logic        clk_i,
  input  walk_ctrl_t  ctrl_i,
  output walk_entry_t rdata_o
);

  localparam int NW = $clog2(MAX_NODES);

  walk_entry_t mem_q [MAX_NODES];
  walk_entry_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (ctrl_i.wr_en) begin
      mem_q[ctrl_i.wr_addr[NW-1:0]] <= ctrl_i.wr_data;
    end
    if (ctrl_i.rd_en) begin
      rdata_q <= mem_q[ctrl_i.rd_addr[NW-1:0]];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> rtl/tsd_dfs_ctrl.sv
// sequencer for edge loads, clears, depth-first walk, order readout and cycle report
module tsd_dfs_ctrl import tsd_pkg::*; #(
  parameter int MAX_NODES = MAX_NODES_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic [COUNT_W-1:0]   node_count_i,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic [1:0]           command_i,
  input  logic [NODE_W-1:0]    from_node_i,
  input  logic [NODE_W-1:0]    to_node_i,
  output adj_ctrl_t            adj_ctrl_o,
  output logic [MAX_NODES-1:0] adj_wdata_o,
  input  logic [MAX_NODES-1:0] adj_row_i,
  output walk_ctrl_t           walk_ctrl_o,
  input  walk_entry_t          walk_rdata_i,
  input  logic                 slot_free_i,
  output out_load_t            out_load_o
);

  localparam int NW = $clog2(MAX_NODES);
  localparam logic [COUNT_W-1:0] MaxCount = COUNT_W'(MAX_NODES);

  typedef enum logic [7:0] {
    ST_IDLE    = 8'b0000_0001,
    ST_EDGE_WR = 8'b0000_0010,
    ST_START   = 8'b0000_0100,
    ST_SCAN    = 8'b0000_1000,
    ST_POP     = 8'b0001_0000,
    ST_EMIT_RD = 8'b0010_0000,
    ST_EMIT_LD = 8'b0100_0000,
    ST_CYCLE   = 8'b1000_0000
  } state_e;

  state_e               state_q, state_d;
  logic [COUNT_W-1:0]   s_q, s_d;
  logic [NODE_W-1:0]    top_u_q, top_u_d;
  logic [COUNT_W-1:0]   top_v_q, top_v_d;
  logic [COUNT_W-1:0]   depth_q, depth_d;
  logic [COUNT_W-1:0]   fill_q, fill_d;
  logic [COUNT_W-1:0]   k_q, k_d;
  logic [NODE_W-1:0]    edge_from_q, edge_from_d;
  logic [NODE_W-1:0]    edge_to_q, edge_to_d;
  logic [MAX_NODES-1:0] on_path_q, on_path_d;
  logic [MAX_NODES-1:0] done_q, done_d;

  logic [COUNT_W-1:0]   n_eff;
  logic [NW-1:0]        v_idx;
  logic [NW-1:0]        s_idx;
  logic [NW-1:0]        u_idx;
  logic [MAX_NODES-1:0] edge_bit;
  logic [COUNT_W-1:0]   fill_m1;
  logic [COUNT_W-1:0]   depth_m1;
  logic [COUNT_W-1:0]   depth_m2;
  logic [COUNT_W-1:0]   k_p1;

  always_comb begin
    if (node_count_i == '0) begin
      n_eff = COUNT_W'(1);
    end else if (node_count_i > MaxCount) begin
      n_eff = MaxCount;
    end else begin
      n_eff = node_count_i;
    end
  end

  assign v_idx    = top_v_q[NW-1:0];
  assign s_idx    = s_q[NW-1:0];
  assign u_idx    = top_u_q[NW-1:0];
  assign fill_m1  = fill_q - COUNT_W'(1);
  assign depth_m1 = depth_q - COUNT_W'(1);
  assign depth_m2 = depth_q - COUNT_W'(2);
  assign k_p1     = k_q + COUNT_W'(1);

  always_comb begin
    edge_bit = '0;
    edge_bit[edge_to_q[NW-1:0]] = 1'b1;
  end

  assign in_ready_o = (state_q == ST_IDLE);

  always_comb begin
    state_d     = state_q;
    s_d         = s_q;
    top_u_d     = top_u_q;
    top_v_d     = top_v_q;
    depth_d     = depth_q;
    fill_d      = fill_q;
    k_d         = k_q;
    edge_from_d = edge_from_q;
    edge_to_d   = edge_to_q;
    on_path_d   = on_path_q;
    done_d      = done_q;
    adj_ctrl_o  = '0;
    adj_wdata_o = adj_row_i | edge_bit;
    walk_ctrl_o = '0;
    out_load_o  = '0;

    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          case (command_i)
            CMD_ADD_EDGE: begin
              if ((COUNT_W'(from_node_i) < MaxCount) && (COUNT_W'(to_node_i) < MaxCount)) begin
                edge_from_d        = from_node_i;
                edge_to_d          = to_node_i;
                adj_ctrl_o.rd_en   = 1'b1;
                adj_ctrl_o.rd_addr = from_node_i;
                state_d            = ST_EDGE_WR;
              end
            end
            CMD_RUN: begin
              on_path_d = '0;
              done_d    = '0;
              fill_d    = n_eff;
              depth_d   = '0;
              s_d       = '0;
              state_d   = ST_START;
            end
            CMD_CLEAR: begin
              adj_ctrl_o.clear = 1'b1;
            end
            default: ;
          endcase
        end
      end

      ST_EDGE_WR: begin
        adj_ctrl_o.wr_en   = 1'b1;
        adj_ctrl_o.wr_addr = edge_from_q;
        state_d            = ST_IDLE;
      end

      ST_START: begin
        if (s_q == n_eff) begin
          k_d     = '0;
          state_d = ST_EMIT_RD;
        end else if (done_q[s_idx]) begin
          s_d = s_q + COUNT_W'(1);
        end else begin
          // root push, top of stack lives in registers
          top_u_d            = s_q[NODE_W-1:0];
          top_v_d            = '0;
          on_path_d[s_idx]   = 1'b1;
          depth_d            = COUNT_W'(1);
          adj_ctrl_o.rd_en   = 1'b1;
          adj_ctrl_o.rd_addr = s_q[NODE_W-1:0];
          state_d            = ST_SCAN;
        end
      end

      ST_SCAN: begin
        if (top_v_q >= n_eff) begin
          // node finished, prepend to order
          done_d[u_idx]         = 1'b1;
          on_path_d[u_idx]      = 1'b0;
          fill_d                = fill_m1;
          depth_d               = depth_m1;
          walk_ctrl_o.wr_en     = 1'b1;
          walk_ctrl_o.wr_addr   = fill_m1[NODE_W-1:0];
          walk_ctrl_o.wr_data   = '{node: top_u_q, next: '0};
          if (depth_q == COUNT_W'(1)) begin
            s_d     = s_q + COUNT_W'(1);
            state_d = ST_START;
          end else begin
            walk_ctrl_o.rd_en   = 1'b1;
            walk_ctrl_o.rd_addr = depth_m2[NODE_W-1:0];
            state_d             = ST_POP;
          end
        end else if (!adj_row_i[v_idx] || done_q[v_idx]) begin
          top_v_d = top_v_q + COUNT_W'(1);
        end else if (on_path_q[v_idx]) begin
          state_d = ST_CYCLE;
        end else begin
          // descend: park current top with resume point, fetch child row
          walk_ctrl_o.wr_en   = 1'b1;
          walk_ctrl_o.wr_addr = depth_m1[NODE_W-1:0];
          walk_ctrl_o.wr_data = '{node: top_u_q, next: top_v_q + COUNT_W'(1)};
          top_u_d             = top_v_q[NODE_W-1:0];
          top_v_d             = '0;
          on_path_d[v_idx]    = 1'b1;
          depth_d             = depth_q + COUNT_W'(1);
          adj_ctrl_o.rd_en    = 1'b1;
          adj_ctrl_o.rd_addr  = top_v_q[NODE_W-1:0];
        end
      end

      ST_POP: begin
        top_u_d            = walk_rdata_i.node;
        top_v_d            = walk_rdata_i.next;
        adj_ctrl_o.rd_en   = 1'b1;
        adj_ctrl_o.rd_addr = walk_rdata_i.node;
        state_d            = ST_SCAN;
      end

      ST_EMIT_RD: begin
        walk_ctrl_o.rd_en   = 1'b1;
        walk_ctrl_o.rd_addr = k_q[NODE_W-1:0];
        state_d             = ST_EMIT_LD;
      end

      ST_EMIT_LD: begin
        if (slot_free_i) begin
          out_load_o.load     = 1'b1;
          out_load_o.node     = walk_rdata_i.node;
          out_load_o.last     = (k_p1 == n_eff);
          out_load_o.no_order = 1'b0;
          k_d                 = k_p1;
          state_d             = (k_p1 == n_eff) ? ST_IDLE : ST_EMIT_RD;
        end
      end

      ST_CYCLE: begin
        if (slot_free_i) begin
          out_load_o.load     = 1'b1;
          out_load_o.node     = '0;
          out_load_o.last     = 1'b1;
          out_load_o.no_order = 1'b1;
          state_d             = ST_IDLE;
        end
      end

      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      s_q       <= '0;
      top_v_q   <= '0;
      depth_q   <= '0;
      fill_q    <= '0;
      k_q       <= '0;
      on_path_q <= '0;
      done_q    <= '0;
    end else begin
      state_q   <= state_d;
      s_q       <= s_d;
      top_v_q   <= top_v_d;
      depth_q   <= depth_d;
      fill_q    <= fill_d;
      k_q       <= k_d;
      on_path_q <= on_path_d;
      done_q    <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    top_u_q     <= top_u_d;
    edge_from_q <= edge_from_d;
    edge_to_q   <= edge_to_d;
  end

endmodule
